// ----- rtl/core/rrt_pkg.sv -----
// Package: types and constants of the route table.
package rrt_pkg;

   localparam int SlotCountDefault = 256;
   localparam int MaxPathsDefault  = 16;
   localparam int ResultCap        = 16;

   localparam logic [16:0] OneQ16 = 17'd65536;

   localparam logic [2:0] KIND_ADD    = 3'd0;
   localparam logic [2:0] KIND_USE    = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_GET    = 3'd3;
   localparam logic [2:0] KIND_QUERY  = 3'd4;
   localparam logic [2:0] KIND_PRUNE  = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] CSR_ROUTE_LIMIT = 3'd0;
   localparam logic [2:0] CSR_PATH_LIMIT  = 3'd1;
   localparam logic [2:0] CSR_FLOOR       = 3'd2;
   localparam logic [2:0] CSR_DECAY       = 3'd3;
   localparam logic [2:0] CSR_LEARN       = 3'd4;
   localparam logic [2:0] CSR_LEARN_ON    = 3'd5;
   localparam logic [2:0] CSR_MULTI_ON    = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] src_key;
      logic [31:0] dest_id;
      logic [16:0] strength;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_dest;
      logic [16:0] found_strength;
      logic [8:0]  pruned_count;
      logic        last;
   } rsp_type;

   // Shared unit opcodes
   localparam logic [1:0] MUL_REINFORCE = 2'd0;
   localparam logic [1:0] MUL_DECAY     = 2'd1;

   typedef struct packed {
      logic [1:0]  op;
      logic [16:0] value;
      logic [16:0] coef;
   } mul_cmd_type;

endpackage

// ----- rtl/core/rrt_mul.sv -----
// Shared Q1.16 multiply unit for reinforcement and decay, one registered result.
module rrt_mul (
   input  logic                 clock,
   input  rrt_pkg::mul_cmd_type cmd,
   output logic [16:0]          result
);
   import rrt_pkg::*;

   logic [16:0] opnd_b;
   logic [33:0] prod;
   logic [34:0] sum;
   logic [16:0] result_in;
   logic [16:0] result_ff;

   always_comb begin
      if (cmd.op == MUL_REINFORCE) begin
         opnd_b = (cmd.value < OneQ16) ? (OneQ16 - cmd.value) : 17'd0;
      end else begin
         opnd_b = cmd.value;
      end
      prod = cmd.coef * opnd_b;
      if (cmd.op == MUL_REINFORCE) begin
         sum = {18'd0, cmd.value} + {17'd0, prod[33:16]};
      end else begin
         sum = {17'd0, prod[33:16]};
      end
      result_in = (sum > {18'd0, OneQ16}) ? OneQ16 : sum[16:0];
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

// ----- rtl/core/reinforced_route_table_unit.sv -----
// Top level of the route table: sequencer, slot memories and result port.
//
// One item is taken at a time; busy stays high from the accepting edge until
// the cycle that carries the item's last result. Every kind starts with one
// walk over all slots, one slot per cycle through the registered read port of
// the slot memories; the result of an add, remove, get strength, prune or
// lookup is sent from the decide state that ends the walk. An add that
// reinforces an existing route first passes through a multiply and a write
// state. A use with learning on reinforces and then decays every route in a
// second walk with a read, a multiply and a write state per slot. A query
// repeats the walk once per returned destination, plus one closing pass
// that finds nothing more unless the path limit is reached first; each
// destination leaves when the following pass decides. The receiver cannot
// stall: each result is on rsp_item for one cycle with rsp_valid high.
module reinforced_route_table_unit #(
   parameter int SLOT_COUNT = rrt_pkg::SlotCountDefault,
   parameter int MAX_PATHS  = rrt_pkg::MaxPathsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrt_pkg::req_type req_item,
   output logic             rsp_valid,
   output rrt_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import rrt_pkg::*;

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int PL = (MAX_PATHS < ResultCap) ? MAX_PATHS : ResultCap;
   localparam int TW = $clog2(PL + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_LAST   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_RMUL   = 4'd4;
   localparam logic [3:0] S_RWR    = 4'd5;
   localparam logic [3:0] S_DRD    = 4'd6;
   localparam logic [3:0] S_DMUL   = 4'd7;
   localparam logic [3:0] S_DWR    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   // configuration
   logic [8:0]  route_limit_ff;
   logic [4:0]  path_limit_ff;
   logic [16:0] floor_ff, decay_ff, learn_ff;
   logic        learn_on_ff, multi_on_ff;

   // slot storage
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [31:0] src_mem [SLOT_COUNT];
   logic [31:0] dst_mem [SLOT_COUNT];
   logic [16:0] str_mem [SLOT_COUNT];
   logic [31:0] rd_src_ff, rd_dst_ff;
   logic [16:0] rd_str_ff;
   logic        rd_valid_ff;

   logic [3:0]    state_ff;
   req_type       cur_ff;
   logic [CW-1:0] total_ff;
   logic [AW-1:0] ptr_ff;      // read address
   logic [AW-1:0] pidx_ff;     // address of data in rd_*_ff
   logic          hit_ff;
   logic [AW-1:0] hit_idx_ff;
   logic [16:0]   hit_str_ff;
   logic          free_ff;
   logic [AW-1:0] free_idx_ff;
   logic          best_ff;
   logic [AW-1:0] best_idx_ff;
   logic [16:0]   best_str_ff;
   logic [31:0]   best_dst_ff;
   logic [16:0]   prev_str_ff;
   logic [AW-1:0] prev_idx_ff;
   logic [CW-1:0] prune_cnt_ff;
   logic [TW-1:0] nout_ff;
   logic [TW-1:0] qlimit;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [16:0]   wr_str;
   logic          wr_all;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   mul_cmd_type mcmd;
   logic [16:0] mres;

   rrt_mul u_mul (.clock(clock), .cmd(mcmd), .result(mres));

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      logic [4:0] lim;
      lim = multi_on_ff ? ((path_limit_ff == 5'd0) ? 5'd1 : path_limit_ff) : 5'd1;
      if ({27'd0, lim} > PL) begin
         qlimit = TW'(PL);
      end else begin
         qlimit = TW'(lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_limit_ff <= 9'd256;
         path_limit_ff  <= 5'd16;
         floor_ff       <= 17'd655;
         decay_ff       <= 17'd65470;
         learn_ff       <= 17'd6554;
         learn_on_ff    <= 1'b1;
         multi_on_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROUTE_LIMIT: route_limit_ff <= csr_data[8:0];
            CSR_PATH_LIMIT:  path_limit_ff  <= csr_data[4:0];
            CSR_FLOOR:       floor_ff       <= csr_data[16:0];
            CSR_DECAY:       decay_ff       <= csr_data[16:0];
            CSR_LEARN:       learn_ff       <= csr_data[16:0];
            CSR_LEARN_ON:    learn_on_ff    <= csr_data[0];
            CSR_MULTI_ON:    multi_on_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // memory read port
   always_ff @(posedge clock) begin
      rd_src_ff   <= src_mem[ptr_ff];
      rd_dst_ff   <= dst_mem[ptr_ff];
      rd_str_ff   <= str_mem[ptr_ff];
      rd_valid_ff <= valid_ff[ptr_ff];
      pidx_ff     <= ptr_ff;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         str_mem[wr_addr] <= wr_str;
         if (wr_all) begin
            src_mem[wr_addr] <= cur_ff.src_key;
            dst_mem[wr_addr] <= cur_ff.dest_id;
         end
      end
   end

   always_comb begin
      mcmd.op    = (state_ff == S_RMUL) ? MUL_REINFORCE : MUL_DECAY;
      mcmd.value = (state_ff == S_RMUL) ? hit_str_ff : rd_str_ff;
      mcmd.coef  = (state_ff == S_RMUL) ? learn_ff : decay_ff;
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_str  = mres;
      wr_all  = 1'b0;
      if (state_ff == S_RWR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_DWR) begin
         wr_en   = rd_valid_ff;
         wr_addr = pidx_ff;
      end else if (state_ff == S_DECIDE && cur_ff.kind == KIND_ADD && !hit_ff
                   && cur_ff.strength <= OneQ16
                   && {{(32-CW){1'b0}}, total_ff} < {23'd0, route_limit_ff}
                   && free_ff) begin
         wr_en   = 1'b1;
         wr_addr = free_idx_ff;
         wr_str  = cur_ff.strength;
         wr_all  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      logic          m;
      logic          q;
      logic          scan_on;
      logic [AW-1:0] last_idx;
      rsp_type       nxt;
      last_idx = AW'(SLOT_COUNT - 1);
      scan_on  = (state_ff == S_SCAN) || (state_ff == S_LAST);
      nxt      = rsp_ff;
      m = rd_valid_ff && rd_src_ff == cur_ff.src_key && rd_dst_ff == cur_ff.dest_id;
      // later passes of a query take only what ranks below the previous pick
      q = rd_valid_ff && rd_src_ff == cur_ff.src_key && rd_str_ff >= floor_ff
          && (nout_ff == '0 || rd_str_ff < prev_str_ff
              || (rd_str_ff == prev_str_ff && pidx_ff > prev_idx_ff));
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // scan pipeline: rd_* holds slot pidx_ff, except in the first cycle
         if (scan_on && !(state_ff == S_SCAN && ptr_ff == '0)) begin
            if (m && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= pidx_ff;
               hit_str_ff <= rd_str_ff;
            end
            if (!rd_valid_ff && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= pidx_ff;
            end
            if (q && (!best_ff || rd_str_ff > best_str_ff)) begin
               best_ff     <= 1'b1;
               best_idx_ff <= pidx_ff;
               best_str_ff <= rd_str_ff;
               best_dst_ff <= rd_dst_ff;
            end
            if (cur_ff.kind == KIND_PRUNE && rd_valid_ff && rd_str_ff < floor_ff) begin
               valid_ff[pidx_ff] <= 1'b0;
               prune_cnt_ff      <= prune_cnt_ff + 1'b1;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cur_ff       <= req_item;
                  ptr_ff       <= '0;
                  hit_ff       <= 1'b0;
                  free_ff      <= 1'b0;
                  best_ff      <= 1'b0;
                  prune_cnt_ff <= '0;
                  nout_ff      <= '0;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               // first cycle fills the read register; skipped by the guard above
               if (ptr_ff == last_idx) begin
                  state_ff <= S_LAST;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
            S_LAST: begin
               ptr_ff   <= '0;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (cur_ff.kind != KIND_QUERY) begin
                  nxt      = '0;
                  nxt.last = 1'b1;
               end
               state_ff <= S_IDLE;
               case (cur_ff.kind)
                  KIND_ADD: begin
                     if (hit_ff) begin
                        nxt.status = ST_OK;
                        if (learn_on_ff) state_ff <= S_RMUL;
                     end else if (cur_ff.strength > OneQ16) begin
                        nxt.status = ST_MISS;
                     end else if ({{(32-CW){1'b0}}, total_ff} >= {23'd0, route_limit_ff}
                                  || !free_ff) begin
                        nxt.status = ST_FULL;
                     end else begin
                        nxt.status = ST_OK;
                        valid_ff[free_idx_ff] <= 1'b1;
                        total_ff              <= total_ff + 1'b1;
                     end
                  end
                  KIND_USE: begin
                     nxt.status = hit_ff ? ST_OK : ST_MISS;
                     if (hit_ff && learn_on_ff) state_ff <= S_RMUL;
                  end
                  KIND_REMOVE: begin
                     nxt.status = hit_ff ? ST_OK : ST_MISS;
                     if (hit_ff) begin
                        valid_ff[hit_idx_ff] <= 1'b0;
                        if (total_ff != '0) total_ff <= total_ff - 1'b1;
                     end
                  end
                  KIND_GET: begin
                     nxt.status = hit_ff ? ST_OK : ST_MISS;
                     if (hit_ff) nxt.found_strength = hit_str_ff;
                  end
                  KIND_QUERY: begin
                     // a held item leaves once this pass tells whether it is last
                     if (best_ff) begin
                        prev_str_ff <= best_str_ff;
                        prev_idx_ff <= best_idx_ff;
                        nout_ff     <= nout_ff + 1'b1;
                        state_ff    <= S_EMIT;
                        if (nout_ff != '0) rsp_valid_ff <= 1'b1;
                     end else if (nout_ff == '0) begin
                        nxt          = '0;
                        nxt.status   = ST_MISS;
                        nxt.last     = 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        nxt.last     = 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                  end
                  KIND_PRUNE: begin
                     nxt.status       = ST_OK;
                     nxt.pruned_count = 9'(prune_cnt_ff);
                     total_ff         <= total_ff - prune_cnt_ff;
                  end
                  default: begin
                     nxt.status = ST_MISS;
                  end
               endcase
               rsp_ff <= nxt;
               if (cur_ff.kind != KIND_QUERY && !(learn_on_ff && hit_ff
                   && (cur_ff.kind == KIND_ADD || cur_ff.kind == KIND_USE))) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_EMIT: begin
               // load the new pick; send it now if the limit is reached, else scan again
               best_ff            <= 1'b0;
               nxt                = '0;
               nxt.status         = ST_OK;
               nxt.found_dest     = best_dst_ff;
               nxt.found_strength = best_str_ff;
               nxt.last           = (nout_ff == qlimit);
               rsp_ff             <= nxt;
               if (nout_ff == qlimit) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_RMUL: begin
               state_ff <= S_RWR;
            end
            S_RWR: begin
               if (cur_ff.kind == KIND_USE) begin
                  ptr_ff   <= '0;
                  state_ff <= S_DRD;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_DRD: begin
               state_ff <= S_DMUL;
            end
            S_DMUL: begin
               state_ff <= S_DWR;
            end
            S_DWR: begin
               if (pidx_ff == last_idx) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= S_DRD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the reinforced route table unit.
`timescale 1ns / 1ps

module tb_top;
   import rrt_pkg::*;

   localparam int SLOTS = 256;
   localparam int PATHS = 16;
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   localparam longint ONE = 65536;

   class route_scoreboard;
      bit          used[SLOTS];
      logic [31:0] src_of[SLOTS];
      logic [31:0] dst_of[SLOTS];
      longint      weight[SLOTS];
      int          total = 0;
      int          route_limit = 256, path_limit = 16;
      longint      floor_q = 655, decay_q = 65470, learn_q = 6554;
      bit          learn_on = 1, multi_on = 1;
      rsp_type     pending[$];
      int          errors = 0;

      function int find(logic [31:0] s, logic [31:0] d);
         for (int i = 0; i < SLOTS; i++)
            if (used[i] && src_of[i] == s && dst_of[i] == d) return i;
         return -1;
      endfunction

      function longint boost(longint s);
         longint head, v;
         head = (s < ONE) ? ONE - s : 0;
         v = s + ((learn_q * head) >> 16);
         return (v > ONE) ? ONE : v;
      endfunction

      function void push(logic [1:0] st, logic [31:0] d, longint s, int cnt, bit lst);
         rsp_type r;
         r.status = st;
         r.found_dest = d;
         r.found_strength = s[16:0];
         r.pruned_count = cnt[8:0];
         r.last = lst;
         pending.push_back(r);
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_ROUTE_LIMIT: route_limit = v[8:0];
            CSR_PATH_LIMIT:  path_limit = v[4:0];
            CSR_FLOOR:       floor_q = v[16:0];
            CSR_DECAY:       decay_q = v[16:0];
            CSR_LEARN:       learn_q = v[16:0];
            CSR_LEARN_ON:    learn_on = v[0];
            CSR_MULTI_ON:    multi_on = v[0];
            default: ;
         endcase
      endfunction

      function void note_item(req_type r);
         int     idx, n, best, lim, cnt, i;
         bit     taken[SLOTS];
         longint v;
         idx = find(r.src_key, r.dest_id);
         case (r.kind)
            KIND_ADD: begin
               if (idx >= 0) begin
                  if (learn_on) weight[idx] = boost(weight[idx]);
                  push(ST_OK, 0, 0, 0, 1);
               end else if (r.strength > OneQ16) begin
                  push(ST_MISS, 0, 0, 0, 1);
               end else if (total >= route_limit) begin
                  push(ST_FULL, 0, 0, 0, 1);
               end else begin
                  for (i = 0; i < SLOTS; i++)
                     if (!used[i]) break;
                  if (i >= SLOTS) begin
                     push(ST_FULL, 0, 0, 0, 1);
                  end else begin
                     used[i] = 1;
                     src_of[i] = r.src_key;
                     dst_of[i] = r.dest_id;
                     weight[i] = r.strength;
                     total++;
                     push(ST_OK, 0, 0, 0, 1);
                  end
               end
            end
            KIND_USE: begin
               if (idx < 0) begin
                  push(ST_MISS, 0, 0, 0, 1);
               end else begin
                  if (learn_on) begin
                     weight[idx] = boost(weight[idx]);
                     for (i = 0; i < SLOTS; i++)
                        if (used[i]) begin
                           v = (weight[i] * decay_q) >> 16;
                           weight[i] = (v > ONE) ? ONE : v;
                        end
                  end
                  push(ST_OK, 0, 0, 0, 1);
               end
            end
            KIND_REMOVE: begin
               if (idx < 0) begin
                  push(ST_MISS, 0, 0, 0, 1);
               end else begin
                  used[idx] = 0;
                  if (total > 0) total--;
                  push(ST_OK, 0, 0, 0, 1);
               end
            end
            KIND_GET: begin
               if (idx < 0) push(ST_MISS, 0, 0, 0, 1);
               else push(ST_OK, 0, weight[idx], 0, 1);
            end
            KIND_QUERY: begin
               lim = multi_on ? ((path_limit == 0) ? 1 : path_limit) : 1;
               if (lim > PATHS) lim = PATHS;
               n = 0;
               while (n < lim) begin
                  best = -1;
                  for (i = 0; i < SLOTS; i++) begin
                     if (!used[i] || taken[i] || src_of[i] != r.src_key) continue;
                     if (weight[i] < floor_q) continue;
                     if (best < 0 || weight[i] > weight[best]) best = i;
                  end
                  if (best < 0) break;
                  taken[best] = 1;
                  push(ST_OK, dst_of[best], weight[best], 0, 0);
                  n++;
               end
               if (n == 0) push(ST_MISS, 0, 0, 0, 1);
               else pending[pending.size() - 1].last = 1;
            end
            KIND_PRUNE: begin
               cnt = 0;
               for (i = 0; i < SLOTS; i++)
                  if (used[i] && weight[i] < floor_q) begin
                     used[i] = 0;
                     if (total > 0) total--;
                     cnt++;
                  end
               push(ST_OK, 0, 0, cnt, 1);
            end
            default: push(ST_MISS, 0, 0, 0, 1);
         endcase
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.found_dest !== e.found_dest) begin
            $error("found_dest: expected %0h, got %0h", e.found_dest, a.found_dest);
            errors++;
         end
         if (a.found_strength !== e.found_strength) begin
            $error("found_strength: expected %0d, got %0d",
                   e.found_strength, a.found_strength);
            errors++;
         end
         if (a.pruned_count !== e.pruned_count) begin
            $error("pruned_count: expected %0d, got %0d", e.pruned_count, a.pruned_count);
            errors++;
         end
         if (a.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, a.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   route_scoreboard table_sb = new();
   int          cycles = 0;

   reinforced_route_table_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // check results before noting a new item: a result here belongs to an older one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) table_sb.check_result(rsp_item);
         if (start && !busy) table_sb.note_item(req_item);
         if (csr_valid && csr_ready) table_sb.write_reg(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic issue(input logic [2:0] k, input logic [31:0] s, input logic [31:0] d,
                        input logic [16:0] w, input bit calm);
      req_type r;
      r.kind = k;
      r.src_key = s;
      r.dest_id = d;
      r.strength = w;
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start <= 1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   // step past the accepting edge first so the item just taken is seen
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (table_sb.pending.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic set_regs(input int rl, input int pl, input int fl, input int dc,
                           input int lr, input int lo, input int mo);
      int vals[7];
      vals = '{rl, pl, fl, dc, lr, lo, mo};
      drain();
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1;
         csr_index <= i[2:0];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 0;
   endtask

   task automatic random_item(input bit calm);
      int          pick;
      logic [2:0]  k;
      logic [31:0] s, d;
      logic [16:0] w;
      pick = $urandom_range(0, 99);
      k = (pick < 30) ? KIND_ADD : (pick < 45) ? KIND_USE : (pick < 55) ? KIND_REMOVE :
          (pick < 70) ? KIND_GET : (pick < 88) ? KIND_QUERY : (pick < 96) ? KIND_PRUNE :
          (pick < 98) ? KIND_SPARE_LO : KIND_SPARE_HI;
      s = ($urandom_range(0, 9) == 0) ? $urandom : 32'h5A00_0000 + $urandom_range(0, 2);
      d = ($urandom_range(0, 9) == 0) ? $urandom : 32'hC300_0000 + $urandom_range(0, 23);
      w = ($urandom_range(0, 6) == 0) ? 17'($urandom_range(0, 131071))
                                      : 17'($urandom_range(0, 65536));
      issue(k, s, d, w, calm);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults
      issue(KIND_ADD, 32'h1, 32'h10, 17'd65536, 0);
      issue(KIND_ADD, 32'h1, 32'h11, 17'd0, 0);
      issue(KIND_ADD, 32'h1, 32'h12, 17'h1FFFF, 0);
      issue(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd40000, 0);
      issue(KIND_ADD, 32'h1, 32'h13, 17'd40000, 0);
      issue(KIND_ADD, 32'h1, 32'h10, 17'h1FFFF, 0);
      issue(KIND_USE, 32'h1, 32'h13, 17'd0, 0);
      issue(KIND_USE, 32'h2, 32'h13, 17'd0, 0);
      issue(KIND_GET, 32'h1, 32'h13, 17'd0, 0);
      issue(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0, 0);
      issue(KIND_GET, 32'h0, 32'h0, 17'd0, 0);
      issue(KIND_QUERY, 32'h1, 32'h0, 17'd0, 0);
      issue(KIND_QUERY, 32'h7, 32'h0, 17'd0, 0);
      issue(KIND_REMOVE, 32'h1, 32'h13, 17'd0, 0);
      issue(KIND_REMOVE, 32'h1, 32'h13, 17'd0, 0);
      issue(KIND_PRUNE, 32'h0, 32'h0, 17'd0, 0);
      issue(KIND_SPARE_LO, 32'h1, 32'h10, 17'd5, 0);
      issue(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF, 0);

      // directed: tight limit, learning and multi-path off
      set_regs(2, 0, 0, 65536, 65536, 0, 0);
      issue(KIND_ADD, 32'h1, 32'h20, 17'd100, 0);
      issue(KIND_ADD, 32'h1, 32'h10, 17'd0, 0);
      issue(KIND_USE, 32'h1, 32'h10, 17'd0, 0);
      issue(KIND_QUERY, 32'h1, 32'h0, 17'd0, 0);
      issue(KIND_PRUNE, 32'h0, 32'h0, 17'd0, 0);

      set_regs(256, 16, 0, 65536, 65536, 1, 1);
      repeat (30) random_item(0);
      set_regs(1, 1, 65536, 0, 0, 0, 0);
      repeat (15) random_item(0);
      set_regs(8, 0, 655, 65470, 6554, 1, 1);
      repeat (25) random_item(0);
      set_regs($urandom_range(1, 256), $urandom_range(1, 16), $urandom_range(0, 65536),
               $urandom_range(0, 65536), $urandom_range(0, 65536),
               $urandom_range(0, 1), $urandom_range(0, 1));
      repeat (30) random_item(0);
      set_regs(256, 16, 300, 60000, 20000, 1, 1);
      repeat (30) random_item(1);

      drain();
      repeat (300) @(posedge clock);
      if (table_sb.pending.size() != 0) begin
         $error("%0d results never arrived", table_sb.pending.size());
         table_sb.errors++;
      end
      if (table_sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/core/rrt_pkg.sv
rtl/core/rrt_mul.sv
rtl/core/reinforced_route_table_unit.sv
tb/tb_top.sv
